// File: hdl/cfpa_pkg.sv
// Shared types, widths and saturation helpers for the complex fixed-point ALU.
// No dependencies; used by cfpa_iter, complex_fixed_point_alu_top, cfpa_checker and tb_top.
package cfpa_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int OP_W      = 3;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int SUM_W  = 2 * WORD_BITS + 2;
   localparam int DEN_W  = 2 * WORD_BITS;
   localparam int CMP_W  = 3 * WORD_BITS + FRAC_BITS + 1;
   localparam int SQ_W   = 2 * WORD_BITS + 1;
   localparam int STAGES = WORD_BITS + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_SDIV = 3'd4,
      OP_CONJ = 3'd5,
      OP_MAG  = 3'd6
   } op_type;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [SUM_W-1:0]     sum_type;

   // Per-item sideband that rides along the divide/root array.
   typedef struct packed {
      op_type  op;
      logic    dbz;
      logic    neg_re;
      logic    neg_im;
      sum_type dir_re;
      sum_type dir_im;
   } side_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // Returns {clamped, word}.
   function automatic logic [WORD_BITS:0] sat_wide(input sum_type v);
      logic [WORD_BITS:0] r;
      if (v > sum_type'(WORD_MAX)) begin
         r = {1'b1, WORD_MAX};
      end else if (v < sum_type'(WORD_MIN)) begin
         r = {1'b1, WORD_MIN};
      end else begin
         r = {1'b0, v[WORD_BITS-1:0]};
      end
      return r;
   endfunction

   // Magnitude quotient q (ovf: q >= 2^WORD_BITS) with sign; returns {clamped, word}.
   function automatic logic [WORD_BITS:0] sat_quot(input logic [WORD_BITS-1:0] q,
                                                   input logic ovf, input logic neg);
      logic [WORD_BITS:0]   r;
      logic [WORD_BITS-1:0] half;
      logic [WORD_BITS-1:0] nq;
      half = {1'b1, {(WORD_BITS-1){1'b0}}};
      nq   = ~q + 1'b1;
      if (neg) begin
         if (ovf || q > half) begin
            r = {1'b1, WORD_MIN};
         end else begin
            r = {1'b0, nq};
         end
      end else if (ovf || q[WORD_BITS-1]) begin
         r = {1'b1, WORD_MAX};
      end else begin
         r = {1'b0, q};
      end
      return r;
   endfunction

endpackage

// File: hdl/cfpa_iter.sv
// Pipelined restoring divider pair, square-root array: one bit per stage after stage 0.
// Depends on cfpa_pkg.
module cfpa_iter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  cfpa_pkg::side_type                   in_side,
   input  logic [cfpa_pkg::CMP_W-1:0]           in_num_re,
   input  logic [cfpa_pkg::CMP_W-1:0]           in_num_im,
   input  logic [cfpa_pkg::DEN_W-1:0]           in_den,
   input  logic [cfpa_pkg::SQ_W-1:0]            in_rad,
   output logic                                 out_valid,
   output cfpa_pkg::side_type                   out_side,
   output logic [cfpa_pkg::WORD_BITS-1:0]       out_q_re,
   output logic                                 out_ovf_re,
   output logic [cfpa_pkg::WORD_BITS-1:0]       out_q_im,
   output logic                                 out_ovf_im,
   output logic [cfpa_pkg::WORD_BITS-1:0]       out_root
);

   localparam int W    = cfpa_pkg::WORD_BITS;
   localparam int LAST = cfpa_pkg::STAGES - 1;

   logic                          valid_ff [0:LAST];
   cfpa_pkg::side_type            side_ff  [0:LAST];
   logic [cfpa_pkg::CMP_W-1:0]    rre_ff   [0:LAST];
   logic [cfpa_pkg::CMP_W-1:0]    rim_ff   [0:LAST];
   logic [cfpa_pkg::DEN_W-1:0]    den_ff   [0:LAST];
   logic [W-1:0]                  qre_ff   [0:LAST];
   logic [W-1:0]                  qim_ff   [0:LAST];
   logic                          ovre_ff  [0:LAST];
   logic                          ovim_ff  [0:LAST];
   logic [cfpa_pkg::SQ_W-1:0]     rad_ff   [0:LAST];
   logic [W-1:0]                  root_ff  [0:LAST];

   for (genvar j = 0; j < cfpa_pkg::STAGES; j++) begin : g_stage
      logic                       valid_in;
      cfpa_pkg::side_type         side_in;
      logic [cfpa_pkg::CMP_W-1:0] rre_in;
      logic [cfpa_pkg::CMP_W-1:0] rim_in;
      logic [cfpa_pkg::DEN_W-1:0] den_in;
      logic [W-1:0]               qre_in;
      logic [W-1:0]               qim_in;
      logic                       ovre_in;
      logic                       ovim_in;
      logic [cfpa_pkg::SQ_W-1:0]  rad_in;
      logic [W-1:0]               root_in;

      if (j == 0) begin : g_first
         logic [cfpa_pkg::CMP_W-1:0] dsh;
         // quotient of 2^W or more can only saturate
         always_comb begin
            dsh      = cfpa_pkg::CMP_W'(in_den) << W;
            valid_in = in_valid;
            side_in  = in_side;
            den_in   = in_den;
            rre_in   = in_num_re;
            rim_in   = in_num_im;
            qre_in   = '0;
            qim_in   = '0;
            ovre_in  = (in_num_re >= dsh);
            ovim_in  = (in_num_im >= dsh);
            rad_in   = in_rad;
            root_in  = '0;
         end
      end else begin : g_next
         localparam int BIT = W - j;
         logic [cfpa_pkg::CMP_W-1:0] dsh;
         logic [cfpa_pkg::SQ_W-1:0]  trial;
         always_comb begin
            dsh      = cfpa_pkg::CMP_W'(den_ff[j-1]) << BIT;
            // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
            trial    = (cfpa_pkg::SQ_W'(root_ff[j-1]) << (BIT + 1))
                       | (cfpa_pkg::SQ_W'(1) << (2 * BIT));
            valid_in = valid_ff[j-1];
            side_in  = side_ff[j-1];
            den_in   = den_ff[j-1];
            rre_in   = rre_ff[j-1];
            rim_in   = rim_ff[j-1];
            qre_in   = qre_ff[j-1];
            qim_in   = qim_ff[j-1];
            ovre_in  = ovre_ff[j-1];
            ovim_in  = ovim_ff[j-1];
            rad_in   = rad_ff[j-1];
            root_in  = root_ff[j-1];
            if (rre_ff[j-1] >= dsh) begin
               rre_in      = rre_ff[j-1] - dsh;
               qre_in[BIT] = 1'b1;
            end
            if (rim_ff[j-1] >= dsh) begin
               rim_in      = rim_ff[j-1] - dsh;
               qim_in[BIT] = 1'b1;
            end
            if (rad_ff[j-1] >= trial) begin
               rad_in       = rad_ff[j-1] - trial;
               root_in[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[j] <= side_in;
            rre_ff[j]  <= rre_in;
            rim_ff[j]  <= rim_in;
            den_ff[j]  <= den_in;
            qre_ff[j]  <= qre_in;
            qim_ff[j]  <= qim_in;
            ovre_ff[j] <= ovre_in;
            ovim_ff[j] <= ovim_in;
            rad_ff[j]  <= rad_in;
            root_ff[j] <= root_in;
         end
      end
   end

   assign out_valid  = valid_ff[LAST];
   assign out_side   = side_ff[LAST];
   assign out_q_re   = qre_ff[LAST];
   assign out_ovf_re = ovre_ff[LAST];
   assign out_q_im   = qim_ff[LAST];
   assign out_ovf_im = ovim_ff[LAST];
   assign out_root   = root_ff[LAST];

endmodule

// File: hdl/complex_fixed_point_alu_top.sv
// Complex Q16.16 ALU: each item passes through 4 front stages, WORD_BITS+1 divide/root
// stages and an output register.
// Throughput one item per cycle; the whole pipeline holds while a result is stalled.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on cfpa_pkg and cfpa_iter.
module complex_fixed_point_alu_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [cfpa_pkg::OP_W-1:0]              req_opcode,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0]  req_a_re,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0]  req_a_im,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0]  req_b_re,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0]  req_b_im,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cfpa_pkg::WORD_BITS-1:0]  rsp_res_re,
   output logic signed [cfpa_pkg::WORD_BITS-1:0]  rsp_res_im,
   output logic                                   rsp_saturated,
   output logic                                   rsp_divide_by_zero
);

   localparam int W = cfpa_pkg::WORD_BITS;
   localparam int F = cfpa_pkg::FRAC_BITS;

   logic advance;

   // stage 0: input register
   logic                s0_valid_ff;
   cfpa_pkg::op_type    s0_op_ff;
   cfpa_pkg::word_type  s0_a_ff, s0_b_ff, s0_c_ff, s0_d_ff;

   // stage 1: products
   logic                s1_valid_ff;
   cfpa_pkg::op_type    s1_op_ff;
   cfpa_pkg::word_type  s1_a_ff, s1_b_ff, s1_c_ff;
   cfpa_pkg::prod_type  s1_m_ff [6];
   cfpa_pkg::prod_type  s1_m_in [6];

   // stage 2: sums
   logic                s2_valid_ff;
   cfpa_pkg::op_type    s2_op_ff;
   cfpa_pkg::sum_type   s2_re_ff, s2_im_ff, s2_den_ff;
   cfpa_pkg::sum_type   s2_re_in, s2_im_in, s2_den_in;

   // stage 3: magnitudes and signs
   logic                     s3_valid_ff;
   cfpa_pkg::op_type         s3_op_ff;
   cfpa_pkg::sum_type        s3_re_ff, s3_im_ff;
   logic [cfpa_pkg::SUM_W-1:0] s3_abs_re_ff, s3_abs_im_ff;
   logic [cfpa_pkg::DEN_W-1:0] s3_den_ff;
   logic                     s3_den_neg_ff, s3_den_zero_ff;
   logic [cfpa_pkg::SUM_W-1:0] abs_re_in, abs_im_in, abs_den_in;

   // array feed
   cfpa_pkg::side_type         side_in;
   logic [cfpa_pkg::SUM_W-1:0] shr_re, shr_im;
   cfpa_pkg::sum_type          resc_re, resc_im;

   // array outputs
   logic                       arr_valid;
   cfpa_pkg::side_type         arr_side;
   logic [W-1:0]               arr_q_re, arr_q_im, arr_root;
   logic                       arr_ovf_re, arr_ovf_im;

   // output register
   logic                rsp_valid_ff;
   cfpa_pkg::word_type  rsp_re_ff, rsp_im_ff;
   logic                rsp_sat_ff, rsp_dbz_ff;
   cfpa_pkg::word_type  rsp_re_in, rsp_im_in;
   logic                rsp_sat_in, rsp_dbz_in;
   logic [W:0]          sat_re, sat_im;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- stage 0 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_op_ff <= cfpa_pkg::op_type'(req_opcode);
         s0_a_ff  <= req_a_re;
         s0_b_ff  <= req_a_im;
         s0_c_ff  <= req_b_re;
         s0_d_ff  <= req_b_im;
      end
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      if (s0_op_ff == cfpa_pkg::OP_MAG) begin
         s1_m_in[0] = cfpa_pkg::prod_type'(s0_a_ff) * cfpa_pkg::prod_type'(s0_a_ff);
         s1_m_in[1] = cfpa_pkg::prod_type'(s0_b_ff) * cfpa_pkg::prod_type'(s0_b_ff);
      end else begin
         s1_m_in[0] = cfpa_pkg::prod_type'(s0_a_ff) * cfpa_pkg::prod_type'(s0_c_ff);
         s1_m_in[1] = cfpa_pkg::prod_type'(s0_b_ff) * cfpa_pkg::prod_type'(s0_d_ff);
      end
      s1_m_in[2] = cfpa_pkg::prod_type'(s0_a_ff) * cfpa_pkg::prod_type'(s0_d_ff);
      s1_m_in[3] = cfpa_pkg::prod_type'(s0_b_ff) * cfpa_pkg::prod_type'(s0_c_ff);
      s1_m_in[4] = cfpa_pkg::prod_type'(s0_c_ff) * cfpa_pkg::prod_type'(s0_c_ff);
      s1_m_in[5] = cfpa_pkg::prod_type'(s0_d_ff) * cfpa_pkg::prod_type'(s0_d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff <= s0_op_ff;
         s1_a_ff  <= s0_a_ff;
         s1_b_ff  <= s0_b_ff;
         s1_c_ff  <= s0_c_ff;
         s1_m_ff  <= s1_m_in;
      end
   end

   // s1_d is only needed for add/sub, taken from the product-free path below
   cfpa_pkg::word_type s1_d_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d_ff <= s0_d_ff;
      end
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      s2_re_in  = '0;
      s2_im_in  = '0;
      s2_den_in = '0;
      unique case (s1_op_ff)
         cfpa_pkg::OP_ADD: begin
            s2_re_in = cfpa_pkg::sum_type'(s1_a_ff) + cfpa_pkg::sum_type'(s1_c_ff);
            s2_im_in = cfpa_pkg::sum_type'(s1_b_ff) + cfpa_pkg::sum_type'(s1_d_ff);
         end
         cfpa_pkg::OP_SUB: begin
            s2_re_in = cfpa_pkg::sum_type'(s1_a_ff) - cfpa_pkg::sum_type'(s1_c_ff);
            s2_im_in = cfpa_pkg::sum_type'(s1_b_ff) - cfpa_pkg::sum_type'(s1_d_ff);
         end
         cfpa_pkg::OP_MUL: begin
            s2_re_in = cfpa_pkg::sum_type'(s1_m_ff[0]) - cfpa_pkg::sum_type'(s1_m_ff[1]);
            s2_im_in = cfpa_pkg::sum_type'(s1_m_ff[2]) + cfpa_pkg::sum_type'(s1_m_ff[3]);
         end
         cfpa_pkg::OP_DIV: begin
            s2_re_in  = cfpa_pkg::sum_type'(s1_m_ff[0]) + cfpa_pkg::sum_type'(s1_m_ff[1]);
            s2_im_in  = cfpa_pkg::sum_type'(s1_m_ff[3]) - cfpa_pkg::sum_type'(s1_m_ff[2]);
            s2_den_in = cfpa_pkg::sum_type'(s1_m_ff[4]) + cfpa_pkg::sum_type'(s1_m_ff[5]);
         end
         cfpa_pkg::OP_SDIV: begin
            s2_re_in  = cfpa_pkg::sum_type'(s1_a_ff);
            s2_im_in  = cfpa_pkg::sum_type'(s1_b_ff);
            s2_den_in = cfpa_pkg::sum_type'(s1_c_ff);
         end
         cfpa_pkg::OP_CONJ: begin
            s2_re_in = cfpa_pkg::sum_type'(s1_a_ff);
            s2_im_in = -cfpa_pkg::sum_type'(s1_b_ff);
         end
         cfpa_pkg::OP_MAG: begin
            s2_re_in = cfpa_pkg::sum_type'(s1_m_ff[0]) + cfpa_pkg::sum_type'(s1_m_ff[1]);
         end
         default: begin
            s2_re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_op_ff  <= s1_op_ff;
         s2_re_ff  <= s2_re_in;
         s2_im_ff  <= s2_im_in;
         s2_den_ff <= s2_den_in;
      end
   end

   // ---------------- stage 3 ----------------
   assign abs_re_in  = s2_re_ff[cfpa_pkg::SUM_W-1]  ? unsigned'(-s2_re_ff)  : unsigned'(s2_re_ff);
   assign abs_im_in  = s2_im_ff[cfpa_pkg::SUM_W-1]  ? unsigned'(-s2_im_ff)  : unsigned'(s2_im_ff);
   assign abs_den_in = s2_den_ff[cfpa_pkg::SUM_W-1] ? unsigned'(-s2_den_ff) : unsigned'(s2_den_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_op_ff       <= s2_op_ff;
         s3_re_ff       <= s2_re_ff;
         s3_im_ff       <= s2_im_ff;
         s3_abs_re_ff   <= abs_re_in;
         s3_abs_im_ff   <= abs_im_in;
         s3_den_ff      <= abs_den_in[cfpa_pkg::DEN_W-1:0];
         s3_den_neg_ff  <= s2_den_ff[cfpa_pkg::SUM_W-1];
         s3_den_zero_ff <= (s2_den_ff == '0);
      end
   end

   // product rescale truncates toward zero
   assign shr_re  = s3_abs_re_ff >> F;
   assign shr_im  = s3_abs_im_ff >> F;
   assign resc_re = s3_re_ff[cfpa_pkg::SUM_W-1] ? -cfpa_pkg::sum_type'(shr_re)
                                                : cfpa_pkg::sum_type'(shr_re);
   assign resc_im = s3_im_ff[cfpa_pkg::SUM_W-1] ? -cfpa_pkg::sum_type'(shr_im)
                                                : cfpa_pkg::sum_type'(shr_im);

   always_comb begin
      side_in.op     = s3_op_ff;
      side_in.dbz    = ((s3_op_ff == cfpa_pkg::OP_DIV) || (s3_op_ff == cfpa_pkg::OP_SDIV))
                       && s3_den_zero_ff;
      side_in.neg_re = s3_re_ff[cfpa_pkg::SUM_W-1] ^ s3_den_neg_ff;
      side_in.neg_im = s3_im_ff[cfpa_pkg::SUM_W-1] ^ s3_den_neg_ff;
      side_in.dir_re = (s3_op_ff == cfpa_pkg::OP_MUL) ? resc_re : s3_re_ff;
      side_in.dir_im = (s3_op_ff == cfpa_pkg::OP_MUL) ? resc_im : s3_im_ff;
   end

   cfpa_iter u_iter (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (s3_valid_ff),
      .in_side    (side_in),
      .in_num_re  (cfpa_pkg::CMP_W'(s3_abs_re_ff) << F),
      .in_num_im  (cfpa_pkg::CMP_W'(s3_abs_im_ff) << F),
      .in_den     (s3_den_ff),
      .in_rad     (s3_abs_re_ff[cfpa_pkg::SQ_W-1:0]),
      .out_valid  (arr_valid),
      .out_side   (arr_side),
      .out_q_re   (arr_q_re),
      .out_ovf_re (arr_ovf_re),
      .out_q_im   (arr_q_im),
      .out_ovf_im (arr_ovf_im),
      .out_root   (arr_root)
   );

   // ---------------- output stage ----------------
   always_comb begin
      rsp_re_in  = '0;
      rsp_im_in  = '0;
      rsp_sat_in = 1'b0;
      rsp_dbz_in = 1'b0;
      sat_re     = '0;
      sat_im     = '0;
      unique case (arr_side.op) inside
         cfpa_pkg::OP_ADD, cfpa_pkg::OP_SUB, cfpa_pkg::OP_MUL, cfpa_pkg::OP_CONJ: begin
            sat_re     = cfpa_pkg::sat_wide(arr_side.dir_re);
            sat_im     = cfpa_pkg::sat_wide(arr_side.dir_im);
            rsp_re_in  = sat_re[W-1:0];
            rsp_im_in  = sat_im[W-1:0];
            rsp_sat_in = sat_re[W] | sat_im[W];
         end
         cfpa_pkg::OP_DIV, cfpa_pkg::OP_SDIV: begin
            if (arr_side.dbz) begin
               rsp_dbz_in = 1'b1;
            end else begin
               sat_re     = cfpa_pkg::sat_quot(arr_q_re, arr_ovf_re, arr_side.neg_re);
               sat_im     = cfpa_pkg::sat_quot(arr_q_im, arr_ovf_im, arr_side.neg_im);
               rsp_re_in  = sat_re[W-1:0];
               rsp_im_in  = sat_im[W-1:0];
               rsp_sat_in = sat_re[W] | sat_im[W];
            end
         end
         cfpa_pkg::OP_MAG: begin
            rsp_re_in  = arr_root[W-1] ? cfpa_pkg::WORD_MAX : arr_root;
            rsp_sat_in = arr_root[W-1];
         end
         default: begin
            rsp_re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= arr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_re_ff  <= rsp_re_in;
         rsp_im_ff  <= rsp_im_in;
         rsp_sat_ff <= rsp_sat_in;
         rsp_dbz_ff <= rsp_dbz_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_re         = rsp_re_ff;
   assign rsp_res_im         = rsp_im_ff;
   assign rsp_saturated      = rsp_sat_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled without output back-pressure");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_dbz_ff) |-> (rsp_re_ff == '0 && rsp_im_ff == '0 && !rsp_sat_ff))
      else $error("divide by zero item carries nonzero result");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> !rsp_dbz_ff)
      else $error("saturated and divide by zero both set");
`endif

endmodule

// File: tb/cfpa_checker.sv
// Checker for the complex fixed-point ALU: watches both channels, predicts each result
// and compares it field by field. Depends on cfpa_pkg.
`timescale 1ns / 100ps
module cfpa_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [cfpa_pkg::OP_W-1:0]             req_opcode,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] req_a_re,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] req_a_im,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] req_b_re,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] req_b_im,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] rsp_res_re,
   input  logic signed [cfpa_pkg::WORD_BITS-1:0] rsp_res_im,
   input  logic                                  rsp_saturated,
   input  logic                                  rsp_divide_by_zero,
   output int                                    fail_count,
   output int                                    pending
);

   typedef logic signed [159:0] wide_type;

   typedef struct packed {
      cfpa_pkg::word_type re;
      cfpa_pkg::word_type im;
      logic               sat;
      logic               dbz;
   } alu_result_type;

   alu_result_type result_q[$];

   function automatic wide_type quot_trunc(wide_type n, wide_type d);
      wide_type an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (an <<< cfpa_pkg::FRAC_BITS) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
   endfunction

   function automatic wide_type shift_trunc(wide_type v);
      wide_type m;
      m = ((v < 0) ? -v : v) >> cfpa_pkg::FRAC_BITS;
      return (v < 0) ? -m : m;
   endfunction

   function automatic cfpa_pkg::word_type clamp(wide_type v, inout logic flag);
      if (v > wide_type'(cfpa_pkg::WORD_MAX)) begin
         flag = 1'b1;
         return cfpa_pkg::WORD_MAX;
      end
      if (v < wide_type'(cfpa_pkg::WORD_MIN)) begin
         flag = 1'b1;
         return cfpa_pkg::WORD_MIN;
      end
      return v[cfpa_pkg::WORD_BITS-1:0];
   endfunction

   function automatic logic [63:0] root_floor(wide_type s);
      logic [63:0] r, t;
      r = '0;
      for (int i = 62; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (wide_type'({96'd0, t}) * wide_type'({96'd0, t}) <= s) r = t;
      end
      return r;
   endfunction

   function automatic alu_result_type predict_alu(logic [cfpa_pkg::OP_W-1:0] opc,
                                                  cfpa_pkg::word_type ar,
                                                  cfpa_pkg::word_type ai,
                                                  cfpa_pkg::word_type br,
                                                  cfpa_pkg::word_type bi);
      wide_type a, b, c, d, re, im, den;
      alu_result_type r;
      logic f;
      a = ar; b = ai; c = br; d = bi;
      re = 0; im = 0; f = 1'b0;
      r.dbz = 1'b0;
      case (opc)
         cfpa_pkg::OP_ADD: begin re = a + c; im = b + d; end
         cfpa_pkg::OP_SUB: begin re = a - c; im = b - d; end
         cfpa_pkg::OP_MUL: begin
            re = shift_trunc(a * c - b * d);
            im = shift_trunc(a * d + b * c);
         end
         cfpa_pkg::OP_DIV: begin
            den = c * c + d * d;
            if (den == 0) r.dbz = 1'b1;
            else begin
               re = quot_trunc(a * c + b * d, den);
               im = quot_trunc(b * c - a * d, den);
            end
         end
         cfpa_pkg::OP_SDIV: begin
            if (c == 0) r.dbz = 1'b1;
            else begin
               re = quot_trunc(a, c);
               im = quot_trunc(b, c);
            end
         end
         cfpa_pkg::OP_CONJ: begin re = a; im = -b; end
         cfpa_pkg::OP_MAG: re = {96'd0, root_floor(a * a + b * b)};
         default: ;
      endcase
      r.re = clamp(re, f);
      r.im = clamp(im, f);
      r.sat = f;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            result_q.push_back(predict_alu(req_opcode, req_a_re, req_a_im,
                                           req_b_re, req_b_im));
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) report_mismatch("unexpected item", 1, 0);
            else begin
               want = result_q.pop_front();
               if (rsp_res_re !== want.re) report_mismatch("res_re", rsp_res_re, want.re);
               if (rsp_res_im !== want.im) report_mismatch("res_im", rsp_res_im, want.im);
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", rsp_saturated, want.sat);
               if (rsp_divide_by_zero !== want.dbz)
                  report_mismatch("divide_by_zero", rsp_divide_by_zero, want.dbz);
            end
         end
      end
      pending = result_q.size();
   end
endmodule

// File: tb/tb_top.sv
// Top of the complex fixed-point ALU testbench: clock, reset, stimulus and verdict.
// Depends on cfpa_pkg, complex_fixed_point_alu_top and cfpa_checker.
`timescale 1ns / 100ps
module tb_top;

   localparam int LATENCY = 38;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, rsp_stall = 1'b0;
   logic req_stall, rsp_valid, rsp_saturated, rsp_divide_by_zero;
   logic [cfpa_pkg::OP_W-1:0] req_opcode = '0;
   cfpa_pkg::word_type req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   cfpa_pkg::word_type rsp_res_re, rsp_res_im;
   int fail_count, pending;
   int recv_idle_pct = 0;
   int hold_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   complex_fixed_point_alu_top DUT (.*);

   cfpa_checker u_checker (.*);

   // receiver: random stall, or a long forced hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic cfpa_pkg::word_type rand_word();
      case ($urandom_range(5))
         0: return cfpa_pkg::WORD_MAX;
         1: return cfpa_pkg::WORD_MIN;
         2: return cfpa_pkg::word_type'($urandom_range(0, 1)) - 0;
         3: return cfpa_pkg::word_type'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
         default: return $urandom;
      endcase
   endfunction

   // valid stays high between items unless the sender idles
   task automatic send_item(logic [cfpa_pkg::OP_W-1:0] opc, cfpa_pkg::word_type ar,
                            cfpa_pkg::word_type ai, cfpa_pkg::word_type br,
                            cfpa_pkg::word_type bi, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opc;
      req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_items(int count, int idle_pct);
      logic [cfpa_pkg::OP_W-1:0] opc;
      for (int i = 0; i < count; i++) begin
         opc = cfpa_pkg::OP_W'($urandom_range(7));
         send_item(opc, rand_word(), rand_word(), rand_word(), rand_word(), idle_pct);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: each operation at the extremes, zero divisors, undefined opcode
      for (int op = 0; op < 8; op++) begin
         send_item(cfpa_pkg::OP_W'(op), cfpa_pkg::WORD_MAX, cfpa_pkg::WORD_MIN,
                   cfpa_pkg::WORD_MIN, cfpa_pkg::WORD_MAX, 0);
         send_item(cfpa_pkg::OP_W'(op), 32'sh1_0000, -32'sh2_8000, 32'sh0_8000,
                   32'sh3_0000, 0);
      end
      send_item(cfpa_pkg::OP_DIV, 32'sh1_0000, 32'sh1_0000, 0, 0, 0);
      send_item(cfpa_pkg::OP_SDIV, 32'sh1_0000, 32'sh1_0000, 0, 32'sh5, 0);
      send_item(cfpa_pkg::OP_SDIV, cfpa_pkg::WORD_MAX, cfpa_pkg::WORD_MIN, 1, 0, 0);
      send_item(cfpa_pkg::OP_CONJ, 0, cfpa_pkg::WORD_MIN, 0, 0, 0);
      send_item(cfpa_pkg::OP_MAG, cfpa_pkg::WORD_MIN, cfpa_pkg::WORD_MIN, 0, 0, 0);
      send_item(cfpa_pkg::OP_DIV, cfpa_pkg::WORD_MIN, cfpa_pkg::WORD_MAX, 1, -1, 0);
      // long hold-off while items keep coming so the pipeline backs up
      hold_cycles = 120;
      recv_idle_pct = 87;
      random_items(280, 7);
      recv_idle_pct = 7;
      random_items(280, 87);
      // pause until everything drains
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      recv_idle_pct = 0;
      random_items(270, 0);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("TB_ERROR");
      $finish;
   end
endmodule
